### sv/entab_pkg.sv
package entab_pkg;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_BLANK   = 8'd32;

  localparam logic [4:0] TAB_WIDTH_RESET = 5'd8;
  localparam logic [4:0] TAB_WIDTH_MIN   = 5'd2;
  localparam logic [4:0] TAB_WIDTH_MAX   = 5'd16;

  // Register index taken from paddr bit 2.
  localparam logic REG_TAB_WIDTH = 1'b0;

  localparam int unsigned QueueDepth = 2;

  // One command from the front: a run of blanks followed by one byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] blanks;
  } cmd_t;

endpackage

### sv/entab_front.sv
module entab_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          tab_width_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  output logic                push_o,
  output entab_pkg::cmd_t     push_cmd_o,
  input  logic                queue_ready_i
);
  import entab_pkg::*;

  logic [3:0] stop_pos_q, stop_pos_d;
  logic [3:0] pend_q, pend_d;
  logic [4:0] next_pos;
  logic       reach;
  logic       accept;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i && queue_ready_i;
  assign next_pos   = {1'b0, stop_pos_q} + 5'd1;
  assign reach      = next_pos >= tab_width_i;

  always_comb begin
    stop_pos_d          = stop_pos_q;
    pend_d              = pend_q;
    push_o              = 1'b0;
    push_cmd_o.out_byte = in_byte_i;
    push_cmd_o.blanks   = 4'd0;
    if (accept) begin
      case (in_byte_i)
        CH_BLANK: begin
          if (reach) begin
            push_o              = 1'b1;
            push_cmd_o.out_byte = CH_TAB;
            stop_pos_d          = 4'd0;
            pend_d              = 4'd0;
          end else begin
            stop_pos_d = next_pos[3:0];
            pend_d     = pend_q + 4'd1;
          end
        end
        CH_TAB, CH_NEWLINE: begin
          push_o     = 1'b1;
          stop_pos_d = 4'd0;
          pend_d     = 4'd0;
        end
        default: begin
          // Pending blanks are flushed ahead of a regular character.
          push_o            = 1'b1;
          push_cmd_o.blanks = pend_q;
          stop_pos_d        = reach ? 4'd0 : next_pos[3:0];
          pend_d            = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_pos_q <= 4'd0;
      pend_q     <= 4'd0;
    end else begin
      stop_pos_q <= stop_pos_d;
      pend_q     <= pend_d;
    end
  end

  // Every pending blank also advanced the position.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q <= stop_pos_q)
    else $error("pending blanks exceed position in tab stop");

endmodule

### sv/entab_queue.sv
module entab_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  entab_pkg::cmd_t     push_cmd_i,
  output logic                ready_o,
  output logic                valid_o,
  output entab_pkg::cmd_t     pop_cmd_o,
  input  logic                pop_i
);
  import entab_pkg::*;

  cmd_t       entry_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign ready_o   = count_q < 2'(QueueDepth);
  assign valid_o   = count_q != 2'd0;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'(QueueDepth))
    else $error("command queue overfilled");

endmodule

### sv/entab_back.sv
module entab_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  entab_pkg::cmd_t     cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);
  import entab_pkg::*;

  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] byte_q, byte_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       can_load;
  logic       finish;

  assign can_load = !out_valid_q || out_ready_i;
  assign finish   = busy_q && can_load && (cnt_q == 4'd0);
  assign cmd_pop_o = cmd_valid_i && (!busy_q || finish);

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (can_load) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        if (cnt_q != 4'd0) begin
          out_byte_d = CH_BLANK;
          out_last_d = 1'b0;
          cnt_d      = cnt_q - 4'd1;
        end else begin
          out_byte_d = byte_q;
          out_last_d = 1'b1;
        end
      end
    end
    if (cmd_pop_o) begin
      busy_d = 1'b1;
      cnt_d  = cmd_i.blanks;
      byte_d = cmd_i.out_byte;
    end else if (finish) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // Only the final result of an item can be anything but a blank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_byte_q == CH_BLANK)
    else $error("non-final result is not a blank");

  // A new command is never taken while the current one still has blanks to emit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != 4'd0 |-> !cmd_pop_o)
    else $error("command taken while blanks remain");

endmodule

### sv/entab_blank_run_to_tabs.sv
// Blank-run to tab compression. One text byte enters per item on the slave
// stream; runs of blanks leave as the fewest tabs and blanks that reach the
// same columns, with tab stops every tab_width columns (APB register at 0x0,
// written values clamped to 2..16, reset 8). A blank that does not reach a
// stop produces no result; a tab, a newline or a blank reaching a stop
// produces one; a regular byte produces its pending blanks followed by
// itself. tlast marks the final result of each item. An item's command goes
// straight into a two-entry command queue; the back end emits one result
// per cycle while the output is not stalled, and the input stalls once
// the queue is full. Write tab_width only while the block is idle.
module entab_blank_run_to_tabs (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast
);
  import entab_pkg::*;

  logic [4:0] tab_width_q, tab_width_d;
  logic [4:0] wdata;
  logic       cfg_write;

  logic       push;
  cmd_t       push_cmd;
  logic       queue_ready;
  logic       queue_valid;
  cmd_t       pop_cmd;
  logic       pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TAB_WIDTH);
  assign wdata     = pwdata[4:0];
  assign prdata    = (paddr[2] == REG_TAB_WIDTH) ? {27'd0, tab_width_q} : 32'd0;

  always_comb begin
    tab_width_d = tab_width_q;
    if (cfg_write) begin
      if (wdata < TAB_WIDTH_MIN) begin
        tab_width_d = TAB_WIDTH_MIN;
      end else if (wdata > TAB_WIDTH_MAX) begin
        tab_width_d = TAB_WIDTH_MAX;
      end else begin
        tab_width_d = wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= TAB_WIDTH_RESET;
    end else begin
      tab_width_q <= tab_width_d;
    end
  end

  entab_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tab_width_i   (tab_width_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_byte_i     (s_axis_tdata),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .queue_ready_i (queue_ready)
  );

  entab_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (queue_ready),
    .valid_o    (queue_valid),
    .pop_cmd_o  (pop_cmd),
    .pop_i      (pop)
  );

  entab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_width_q >= TAB_WIDTH_MIN && tab_width_q <= TAB_WIDTH_MAX)
    else $error("tab width out of range");

endmodule

### sim/entab_blank_run_to_tabs_test.sv
`timescale 1ns / 1ps

module entab_blank_run_to_tabs_test;
  import entab_pkg::*;

  localparam logic [2:0] TAB_WIDTH_ADDR = {REG_TAB_WIDTH, 2'b00};
  localparam logic [2:0] STRAY_ADDR     = {~REG_TAB_WIDTH, 2'b00};
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned NUM_ROWS      = 26;

  typedef enum logic [1:0] {ROW_BYTE, ROW_WIDTH, ROW_STRAY} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic [4:0]  reps;
    logic        known;
    logic [7:0]  want;
  } row_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } emit_t;

  typedef struct packed {
    logic       known;
    logic [7:0] want;
  } tag_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;

  // Predictor state: column inside the current tab stop, held blanks, stop width.
  logic [3:0]  col_in_stop;
  logic [3:0]  blanks_held;
  logic [4:0]  stop_width;

  emit_t       out_expect_q[$];
  tag_t        byte_tag_q[$];

  int unsigned mismatches;
  int unsigned bytes_in;
  int unsigned bytes_out;
  int unsigned widths_set;
  int unsigned longest_burst;
  int unsigned hold_left;
  bit          tx_jitter;
  bit          rx_jitter;

  entab_blank_run_to_tabs u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_regular();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_TAB || b == CH_NEWLINE || b == CH_BLANK);
    return b;
  endfunction

  function automatic logic [4:0] clamp_width(input logic [4:0] v);
    if (v < TAB_WIDTH_MIN) return TAB_WIDTH_MIN;
    if (v > TAB_WIDTH_MAX) return TAB_WIDTH_MAX;
    return v;
  endfunction

  // Queues the output bytes that one input byte causes and advances the column.
  function automatic void predict_byte(input logic [7:0] c);
    logic [4:0] nxt;
    nxt = {1'b0, col_in_stop} + 5'd1;
    if (c == CH_BLANK) begin
      if (nxt >= stop_width) begin
        out_expect_q.push_back('{CH_TAB, 1'b1});
        col_in_stop = '0;
        blanks_held = '0;
      end else begin
        col_in_stop = nxt[3:0];
        blanks_held = blanks_held + 4'd1;
      end
    end else if (c == CH_TAB || c == CH_NEWLINE) begin
      out_expect_q.push_back('{c, 1'b1});
      col_in_stop = '0;
      blanks_held = '0;
    end else begin
      for (int i = 0; i < blanks_held; i++) begin
        out_expect_q.push_back('{CH_BLANK, 1'b0});
      end
      out_expect_q.push_back('{c, 1'b1});
      col_in_stop = (nxt >= stop_width) ? 4'd0 : nxt[3:0];
      blanks_held = '0;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    tag_t  tag;
    emit_t want;
    int    queued;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      tag = (byte_tag_q.size() != 0) ? byte_tag_q.pop_front() : '0;
      queued = out_expect_q.size();
      predict_byte(s_axis_tdata);
      if (out_expect_q.size() - queued > longest_burst) begin
        longest_burst = out_expect_q.size() - queued;
      end
      // A row with a hand-written result replaces what the predictor queued.
      if (tag.known) begin
        while (out_expect_q.size() > queued) void'(out_expect_q.pop_back());
        out_expect_q.push_back('{tag.want, 1'b1});
      end
      bytes_in++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      bytes_out++;
      if (out_expect_q.size() == 0) begin
        report_mismatch($sformatf("output byte %02h with nothing expected", m_axis_tdata));
      end else begin
        want = out_expect_q.pop_front();
        if (m_axis_tdata !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    m_axis_tdata, want.out_byte));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch($sformatf("tlast %0b, expected %0b after byte %02h",
                                    m_axis_tlast, want.last, want.out_byte));
        end
      end
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (rx_jitter) begin
        stall_left = pick_gap();
        m_axis_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic known, input logic [7:0] want);
    int unsigned gap;
    byte_tag_q.push_back('{known, want});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    gap = tx_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (out_expect_q.size() != 0 || byte_tag_q.size() != 0) @(posedge clk_i);
    // Blanks that cause no output may still be inside the block.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_width(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] readback;
    drain_results();
    apb_write(addr, data);
    if (addr[2] == REG_TAB_WIDTH) stop_width = clamp_width(data[4:0]);
    apb_read(TAB_WIDTH_ADDR, readback);
    if (readback !== {27'd0, stop_width}) begin
      report_mismatch($sformatf("tab_width reads %0d, expected %0d", readback, stop_width));
    end
    widths_set++;
  endtask

  // Mostly text made of words, blank runs, tabs and line ends, with some raw noise.
  task automatic send_text(input int quota);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = $urandom_range(1, 5);
        repeat (len) send_byte(pick_regular(), 1'b0, '0);
      end else if (r < 62) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * stop_width)
                                          : $urandom_range(1, stop_width);
        repeat (len) send_byte(CH_BLANK, 1'b0, '0);
      end else if (r < 70) begin
        len = 1;
        send_byte(CH_TAB, 1'b0, '0);
      end else if (r < 78) begin
        len = 1;
        send_byte(CH_NEWLINE, 1'b0, '0);
      end else if (r < 88) begin
        // Longest possible run: a fresh line, blanks up to one short of the stop, a byte.
        len = stop_width + 1;
        send_byte(CH_NEWLINE, 1'b0, '0);
        repeat (stop_width - 1) send_byte(CH_BLANK, 1'b0, '0);
        send_byte(pick_regular(), 1'b0, '0);
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
      sent += len;
    end
  endtask

  function automatic logic [31:0] phase_width_word(input int phase);
    logic [4:0] v;
    if (phase == 0) begin
      v = TAB_WIDTH_MAX;
    end else if (phase == 1) begin
      v = TAB_WIDTH_MIN;
    end else begin
      case ($urandom_range(0, 4))
        0:       v = TAB_WIDTH_MIN;
        1:       v = TAB_WIDTH_MAX;
        2:       v = 5'($urandom_range(0, 1));
        3:       v = 5'($urandom_range(17, 31));
        default: v = 5'($urandom_range(2, 16));
      endcase
    end
    return {27'($urandom() >> 5), v};
  endfunction

  initial begin : stimulus
    row_t plan [NUM_ROWS];
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    col_in_stop   = '0;
    blanks_held   = '0;
    stop_width    = TAB_WIDTH_RESET;
    mismatches    = 0;
    bytes_in      = 0;
    bytes_out     = 0;
    widths_set    = 0;
    longest_burst = 0;
    hold_left     = 0;
    tx_jitter     = 1'b1;
    rx_jitter     = 1'b1;

    plan = '{
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b0, 8'h00},
      '{ROW_BYTE,  CH_TAB,     5'd1, 1'b1, CH_TAB},      // tab swallows the held blank
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b0, 8'h00},
      '{ROW_BYTE,  CH_NEWLINE, 5'd1, 1'b1, CH_NEWLINE},  // trailing blank dropped
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b0, 8'h00},
      '{ROW_BYTE,  8'h41,      5'd1, 1'b0, 8'h00},
      '{ROW_BYTE,  CH_BLANK,   5'd5, 1'b0, 8'h00},
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b1, CH_TAB},      // run reaches the stop
      '{ROW_BYTE,  8'h00,      5'd1, 1'b1, 8'h00},
      '{ROW_BYTE,  8'hFF,      5'd1, 1'b1, 8'hFF},
      '{ROW_WIDTH, 32'h20,     5'd0, 1'b0, 8'h00},       // clamps to the minimum
      '{ROW_BYTE,  8'h79,      5'd1, 1'b1, 8'h79},       // column past the new stop wraps
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b0, 8'h00},
      '{ROW_BYTE,  8'h7A,      5'd1, 1'b0, 8'h00},
      '{ROW_WIDTH, 32'h1F,     5'd0, 1'b0, 8'h00},       // clamps to the maximum
      '{ROW_BYTE,  8'h71,      5'd1, 1'b0, 8'h00},
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b0, 8'h00},
      '{ROW_WIDTH, 32'h01,     5'd0, 1'b0, 8'h00},
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b1, CH_TAB},      // column past the new stop
      '{ROW_STRAY, 32'h05,     5'd0, 1'b0, 8'h00},
      '{ROW_BYTE,  8'h72,      5'd1, 1'b1, 8'h72},
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b1, CH_TAB},      // lone blank at the stop
      '{ROW_BYTE,  8'h01,      5'd1, 1'b0, 8'h00},       // control byte counts as text
      '{ROW_BYTE,  CH_BLANK,   5'd1, 1'b0, 8'h00},
      '{ROW_BYTE,  8'h80,      5'd1, 1'b0, 8'h00},
      '{ROW_WIDTH, 32'h08,     5'd0, 1'b0, 8'h00}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      case (plan[i].kind)
        ROW_BYTE: begin
          repeat (plan[i].reps) send_byte(plan[i].value[7:0], plan[i].known, plan[i].want);
        end
        ROW_WIDTH: set_width(TAB_WIDTH_ADDR, plan[i].value);
        ROW_STRAY: set_width(STRAY_ADDR, plan[i].value);
        default: ;
      endcase
    end

    for (int p = 0; p < 10; p++) begin
      // Every fourth phase runs without gaps on either side.
      tx_jitter = (p % 4 != 2);
      rx_jitter = tx_jitter;
      set_width(TAB_WIDTH_ADDR, phase_width_word(p));
      if (p == 5) set_width(STRAY_ADDR, $urandom());
      // The output side stays closed for a long time while text keeps coming.
      if (p == 3) hold_left = 300;
      send_text(15);
      if (p == 6) drain_results();
      send_text(13);
    end

    drain_results();
    $display("Sent %0d text bytes under %0d tab width settings; checked %0d output bytes.",
             bytes_in, widths_set, bytes_out);
    $display("Longest output burst from one byte: %0d; mismatches: %0d.",
             longest_burst, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
